// ----- rtl/awa_pkg.sv -----
// Shared types, constants and helpers for the address window allocator.
// No dependencies; imported by every module of the block.
`default_nettype none

package awa_pkg;

  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned HI_W        = 16;
  localparam int unsigned TGT_W       = 4;
  localparam int unsigned ATTR_W      = 8;
  localparam int unsigned END_W       = 34;
  localparam int unsigned CFG_W       = 6;
  localparam int unsigned CMP_W       = CFG_W + 1;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned IDX_OUT_W   = 5;
  localparam int unsigned IN_TDATA_W  = 112;
  localparam int unsigned OUT_TDATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_WIN_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REMAP_WIN  = 2'd1;

  localparam logic [CFG_W-1:0] WIN_IN_USE_RST = 6'd20;
  localparam logic [CFG_W-1:0] REMAP_WIN_RST  = 6'd8;

  localparam logic KIND_ADD = 1'b0;
  localparam logic KIND_DEL = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_CONFLICT  = 2'd1,
    ST_NO_FREE   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_SCAN,
    CS_COMMIT,
    CS_RESP
  } ctl_state_e;

  typedef struct packed {
    logic [CFG_W-1:0] win_in_use;
    logic [CFG_W-1:0] remap_win;
  } cfg_t;

  typedef struct packed {
    logic              kind;
    logic [TGT_W-1:0]  target;
    logic [ATTR_W-1:0] attr;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] size;
    logic              has_remap;
    logic [ADDR_W-1:0] remap;
  } item_t;

  typedef struct packed {
    logic [HI_W-1:0]   base_hi;
    logic [HI_W-1:0]   size_f;
    logic [TGT_W-1:0]  target;
    logic [ATTR_W-1:0] attr;
    logic [HI_W-1:0]   remap_seg;
  } win_entry_t;

  typedef struct packed {
    logic       we;
    logic       live;
    logic       remap_we;
    win_entry_t entry;
  } wr_req_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] idx;
    status_e              status;
  } res_t;

  // Last byte of a stored window; all ones stands for a wrap past 2^32.
  function automatic logic [END_W-1:0] win_end(logic [HI_W-1:0] bh, logic [HI_W-1:0] sf);
    logic [ADDR_W:0] sum;
    sum = {1'b0, bh, 16'h0000} + {1'b0, sf, 16'hffff};
    if (sf != 16'hffff) begin
      return {1'b0, sum};
    end else if (bh == 16'h0000) begin
      return '1;
    end else begin
      return {2'b00, {bh, 16'h0000} - 32'd1};
    end
  endfunction

  // Last byte of a requested range, same wrap convention.
  function automatic logic [END_W-1:0] req_end(logic [ADDR_W-1:0] base,
                                               logic [ADDR_W-1:0] size);
    logic [ADDR_W:0] sum;
    sum = {1'b0, base} + {1'b0, size};
    if (sum == '0) begin
      return '1;
    end else begin
      return {1'b0, sum - 33'd1};
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/awa_table.sv -----
// Window table: enable flags in flops, window fields in a synchronous memory.
// Depends on awa_pkg.
`default_nettype none

module awa_table import awa_pkg::*; #(
  parameter int unsigned MAX_WINDOWS = 32,
  localparam int unsigned IDX_W = $clog2(MAX_WINDOWS)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  output win_entry_t       rd_data_o,
  output logic             rd_live_o,
  input  wr_req_t          wr_i,
  input  logic [IDX_W-1:0] wr_addr_i
);

  win_entry_t             mem_q [MAX_WINDOWS];
  logic [MAX_WINDOWS-1:0] en_q;
  win_entry_t             rd_data_q;
  logic                   rd_live_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= '0;
    end else if (wr_i.we) begin
      en_q[wr_addr_i] <= wr_i.live;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_addr_i].base_hi <= wr_i.entry.base_hi;
      mem_q[wr_addr_i].size_f  <= wr_i.entry.size_f;
      mem_q[wr_addr_i].target  <= wr_i.entry.target;
      mem_q[wr_addr_i].attr    <= wr_i.entry.attr;
      if (wr_i.remap_we) begin
        mem_q[wr_addr_i].remap_seg <= wr_i.entry.remap_seg;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_live_q <= 1'b0;
    end else if (rd_en_i) begin
      rd_live_q <= en_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign rd_live_o = rd_live_q;

endmodule

`default_nettype wire

// ----- rtl/awa_ctrl.sv -----
// Scan sequencer: walks the window table, checks overlap and matches,
// tracks free windows and commits the write. Depends on awa_pkg.
`default_nettype none

module awa_ctrl import awa_pkg::*; #(
  parameter int unsigned MAX_WINDOWS = 32,
  localparam int unsigned IDX_W = $clog2(MAX_WINDOWS),
  localparam int unsigned CNT_W = $clog2(MAX_WINDOWS + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             in_valid_i,
  input  item_t            in_item_i,
  output logic             in_ready_o,
  output logic             rd_en_o,
  output logic [IDX_W-1:0] rd_addr_o,
  input  win_entry_t       rd_data_i,
  input  logic             rd_live_i,
  output wr_req_t          wr_o,
  output logic [IDX_W-1:0] wr_addr_o,
  output logic             res_valid_o,
  output res_t             res_o,
  input  logic             res_ready_i
);

  ctl_state_e state_q, state_d;

  logic              kind_q;
  logic [TGT_W-1:0]  tgt_q;
  logic [ATTR_W-1:0] attr_q;
  logic [ADDR_W-1:0] base_q;
  logic [END_W-1:0]  end_q;
  logic [HI_W-1:0]   size_hi_m1_q;
  logic              size_lo_zero_q;
  logic [HI_W-1:0]   size_field_q;
  logic              has_remap_q;
  logic [HI_W-1:0]   remap_seg_q;

  logic [CNT_W-1:0] cnt_q;
  logic             rd_vld_q;
  logic [IDX_W-1:0] rd_idx_q;
  logic             hit_q;
  logic [IDX_W-1:0] hit_idx_q;
  logic             hi_fnd_q;
  logic [IDX_W-1:0] hi_idx_q;
  logic             any_fnd_q;
  logic [IDX_W-1:0] any_idx_q;
  res_t             res_q;

  logic [CMP_W-1:0]  n_cmp;
  logic [CNT_W-1:0]  win_cnt;
  logic [ADDR_W-1:0] wb32;
  logic              ovl;
  logic              same_dev;
  logic              del_match;
  logic              hit;
  logic              free_eval;
  logic              idx_hi_ok;
  logic              issue;
  logic              scan_done;
  logic              accept;
  status_e           cm_status;
  logic [IDX_W-1:0]  cm_idx;

  always_comb begin
    n_cmp = ({1'b0, cfg_i.win_in_use} > CMP_W'(MAX_WINDOWS)) ?
            CMP_W'(MAX_WINDOWS) : {1'b0, cfg_i.win_in_use};
    win_cnt = n_cmp[CNT_W-1:0];
  end

  always_comb begin
    wb32      = {rd_data_i.base_hi, 16'h0000};
    ovl       = ({2'b00, base_q} < win_end(rd_data_i.base_hi, rd_data_i.size_f)) &&
                (end_q > {2'b00, wb32});
    same_dev  = (tgt_q == rd_data_i.target) && (attr_q == rd_data_i.attr);
    del_match = (base_q == wb32) && size_lo_zero_q && (rd_data_i.size_f == size_hi_m1_q);
    hit       = rd_vld_q && rd_live_i && ((kind_q == KIND_DEL) ? del_match : (ovl || same_dev));
    free_eval = rd_vld_q && !rd_live_i;
    idx_hi_ok = CMP_W'(rd_idx_q) >= {1'b0, cfg_i.remap_win};
    issue     = (state_q == CS_SCAN) && (cnt_q < win_cnt) && !hit;
    scan_done = hit || (cnt_q >= win_cnt);
    accept    = (state_q == CS_IDLE) && in_valid_i;
  end

  always_comb begin
    cm_status = ST_NO_FREE;
    cm_idx    = '0;
    if (kind_q == KIND_ADD) begin
      priority if (hit_q) begin
        cm_status = ST_CONFLICT;
      end else if (!has_remap_q && hi_fnd_q) begin
        cm_status = ST_OK;
        cm_idx    = hi_idx_q;
      end else if (any_fnd_q) begin
        cm_status = ST_OK;
        cm_idx    = any_idx_q;
      end else begin
        cm_status = ST_NO_FREE;
      end
    end else if (hit_q) begin
      cm_status = ST_OK;
      cm_idx    = hit_idx_q;
    end else begin
      cm_status = ST_NOT_FOUND;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CS_IDLE:   if (in_valid_i) state_d = CS_SCAN;
      CS_SCAN:   if (scan_done) state_d = CS_COMMIT;
      CS_COMMIT: state_d = CS_RESP;
      CS_RESP:   if (res_ready_i) state_d = CS_IDLE;
      default:   state_d = CS_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == CS_IDLE);
    rd_en_o     = issue;
    rd_addr_o   = cnt_q[IDX_W-1:0];
    res_valid_o = (state_q == CS_RESP);
    res_o       = res_q;
    wr_addr_o   = cm_idx;
    wr_o.we       = (state_q == CS_COMMIT) && (cm_status == ST_OK);
    wr_o.live     = (kind_q == KIND_ADD);
    wr_o.remap_we = CMP_W'(cm_idx) < {1'b0, cfg_i.remap_win};
    if (kind_q == KIND_ADD) begin
      wr_o.entry.base_hi   = base_q[ADDR_W-1:HI_W];
      wr_o.entry.size_f    = size_field_q;
      wr_o.entry.target    = tgt_q;
      wr_o.entry.attr      = attr_q;
      wr_o.entry.remap_seg = remap_seg_q;
    end else begin
      wr_o.entry = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= CS_IDLE;
      cnt_q     <= '0;
      rd_vld_q  <= 1'b0;
      hit_q     <= 1'b0;
      hi_fnd_q  <= 1'b0;
      any_fnd_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        cnt_q     <= '0;
        rd_vld_q  <= 1'b0;
        hit_q     <= 1'b0;
        hi_fnd_q  <= 1'b0;
        any_fnd_q <= 1'b0;
      end else begin
        rd_vld_q <= issue;
        if (issue) begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
        if (hit) begin
          hit_q <= 1'b1;
        end
        if (free_eval && !any_fnd_q) begin
          any_fnd_q <= 1'b1;
        end
        if (free_eval && idx_hi_ok && !hi_fnd_q) begin
          hi_fnd_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q         <= in_item_i.kind;
      tgt_q          <= in_item_i.target;
      attr_q         <= in_item_i.attr;
      base_q         <= in_item_i.base;
      end_q          <= req_end(in_item_i.base, in_item_i.size);
      size_hi_m1_q   <= in_item_i.size[ADDR_W-1:HI_W] - 16'd1;
      size_lo_zero_q <= (in_item_i.size[HI_W-1:0] == '0);
      size_field_q   <= HI_W'((in_item_i.size - 32'd1) >> HI_W);
      has_remap_q    <= in_item_i.has_remap;
      remap_seg_q    <= in_item_i.has_remap ? in_item_i.remap[ADDR_W-1:HI_W] :
                                              in_item_i.base[ADDR_W-1:HI_W];
    end
    rd_idx_q <= cnt_q[IDX_W-1:0];
    if (hit) begin
      hit_idx_q <= rd_idx_q;
    end
    if (free_eval && !any_fnd_q) begin
      any_idx_q <= rd_idx_q;
    end
    if (free_eval && idx_hi_ok && !hi_fnd_q) begin
      hi_idx_q <= rd_idx_q;
    end
    if (state_q == CS_COMMIT) begin
      res_q.status <= cm_status;
      res_q.idx    <= (cm_status == ST_OK) ? IDX_OUT_W'(cm_idx) : '0;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/address_window_allocator.sv -----
// Top level of the address window allocator: stream ports, configuration
// registers, output register. Uses awa_pkg, awa_table and awa_ctrl.
`default_nettype none

// Takes add and delete requests for address decode windows and answers each
// with one status item. An item is scanned against the window table one entry
// per cycle through the table memory's single read port, over at most n entries,
// where n is windows_in_use clamped to MAX_WINDOWS; the scan
// stops early at the first conflict or delete match. One item is in flight at
// a time; the next one is taken while a finished result waits in the output
// register. Write configuration only while no item is in flight.
module address_window_allocator import awa_pkg::*; #(
  parameter int unsigned MAX_WINDOWS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_addr_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // target_id[3:0], attr[11:4], window_base[43:12], window_size[75:44],
  // has_remap[76], remap_address[108:77], zero fill above
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // kind
  input  logic                   s_axis_tuser_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // status[1:0], window_index[6:2], zero fill above
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  localparam int unsigned IDX_W = $clog2(MAX_WINDOWS);

  cfg_t             cfg_q;
  item_t            item;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  win_entry_t       rd_data;
  logic             rd_live;
  wr_req_t          wr_req;
  logic [IDX_W-1:0] wr_addr;
  logic             res_valid;
  logic             res_ready;
  res_t             res;
  logic             out_vld_q;
  res_t             out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.win_in_use <= WIN_IN_USE_RST;
      cfg_q.remap_win  <= REMAP_WIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_WIN_IN_USE: cfg_q.win_in_use <= cfg_wdata_i;
        CFG_REMAP_WIN:  cfg_q.remap_win  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    item.kind      = s_axis_tuser_i;
    item.target    = s_axis_tdata_i[3:0];
    item.attr      = s_axis_tdata_i[11:4];
    item.base      = s_axis_tdata_i[43:12];
    item.size      = s_axis_tdata_i[75:44];
    item.has_remap = s_axis_tdata_i[76];
    item.remap     = s_axis_tdata_i[108:77];
  end

  awa_ctrl #(
    .MAX_WINDOWS(MAX_WINDOWS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid_i),
    .in_item_i  (item),
    .in_ready_o (s_axis_tready_o),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data),
    .rd_live_i  (rd_live),
    .wr_o       (wr_req),
    .wr_addr_o  (wr_addr),
    .res_valid_o(res_valid),
    .res_o      (res),
    .res_ready_i(res_ready)
  );

  awa_table #(
    .MAX_WINDOWS(MAX_WINDOWS)
  ) u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data),
    .rd_live_o(rd_live),
    .wr_i     (wr_req),
    .wr_addr_i(wr_addr)
  );

  assign res_ready = !out_vld_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(OUT_TDATA_W - $bits(res_t)){1'b0}}, out_q};

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_req.we |-> !rd_en)
    else $error("table written during a scan read");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("item taken while another is in flight");

  a_single_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_req.we |=> !wr_req.we)
    else $error("table written twice for one item");

  a_idx_zero_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && out_q.status != ST_OK) |-> (out_q.idx == '0))
    else $error("nonzero window index on a failed item");

endmodule

`default_nettype wire

// ----- tb/address_window_allocator_checker.sv -----
// Scoreboard for the address window allocator: keeps its own copy of the window
// table and settings, predicts the status item of each request and checks results.
// Uses awa_pkg; instantiated beside the block by address_window_allocator_tb.
module address_window_allocator_checker import awa_pkg::*; #(
  parameter int unsigned MAX_WINDOWS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_addr_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i,
  input  logic                   req_valid_i,
  input  logic                   req_ready_i,
  // target_id, attr, window_base, window_size, has_remap, remap_address
  input  logic [IN_TDATA_W-1:0]  req_data_i,
  // kind
  input  logic                   req_kind_i,
  input  logic                   ans_valid_i,
  input  logic                   ans_ready_i,
  // status, window_index
  input  logic [OUT_TDATA_W-1:0] ans_data_i,
  output int unsigned            pending_o,
  output int unsigned            fail_count_o
);

  logic [MAX_WINDOWS-1:0] win_live;
  logic [HI_W-1:0]        win_base_hi   [MAX_WINDOWS];
  logic [HI_W-1:0]        win_size_f    [MAX_WINDOWS];
  logic [TGT_W-1:0]       win_target    [MAX_WINDOWS];
  logic [ATTR_W-1:0]      win_attr      [MAX_WINDOWS];
  logic [HI_W-1:0]        win_remap_seg [MAX_WINDOWS];
  logic [CFG_W-1:0]       win_in_use;
  logic [CFG_W-1:0]       remap_win;
  res_t                   answer_q [$];

  function automatic logic [ADDR_W-1:0] window_span(int unsigned w);
    return {win_size_f[w], 16'hffff} + 32'd1;
  endfunction

  function automatic logic [63:0] window_last(int unsigned w);
    return {32'd0, win_base_hi[w], 16'h0000} + {32'd0, window_span(w)} - 64'd1;
  endfunction

  function automatic void claim_window(int unsigned w, item_t req);
    logic [ADDR_W-1:0] size_m1;
    logic [ADDR_W-1:0] remap_src;
    size_m1 = req.size - 32'd1;
    remap_src = req.has_remap ? req.remap : req.base;
    win_live[w] = 1'b1;
    win_base_hi[w] = req.base[31:16];
    win_size_f[w] = size_m1[31:16];
    win_target[w] = req.target;
    win_attr[w] = req.attr;
    if (w < remap_win) begin
      win_remap_seg[w] = remap_src[31:16];
    end
  endfunction

  function automatic void release_window(int unsigned w);
    win_live[w] = 1'b0;
    win_base_hi[w] = '0;
    win_size_f[w] = '0;
    win_target[w] = '0;
    win_attr[w] = '0;
    if (w < remap_win) begin
      win_remap_seg[w] = '0;
    end
  endfunction

  function automatic res_t update_window_table(item_t req);
    int unsigned n;
    logic [63:0] req_last;
    logic        clash;
    logic        done;
    res_t        r;
    n = (win_in_use > MAX_WINDOWS) ? MAX_WINDOWS : win_in_use;
    r.status = ST_NO_FREE;
    r.idx = '0;
    clash = 1'b0;
    done = 1'b0;
    if (req.kind == KIND_ADD) begin
      req_last = {32'd0, req.base} + {32'd0, req.size} - 64'd1;
      for (int unsigned w = 0; w < n; w++) begin
        if (win_live[w]) begin
          if ({32'd0, req.base} < window_last(w) &&
              req_last > {32'd0, win_base_hi[w], 16'h0000}) begin
            clash = 1'b1;
          end
          if (req.target == win_target[w] && req.attr == win_attr[w]) begin
            clash = 1'b1;
          end
        end
      end
      if (clash) begin
        r.status = ST_CONFLICT;
      end else begin
        if (!req.has_remap) begin
          for (int unsigned w = remap_win; w < n; w++) begin
            if (!done && !win_live[w]) begin
              claim_window(w, req);
              r.idx = IDX_OUT_W'(w);
              done = 1'b1;
            end
          end
        end
        for (int unsigned w = 0; w < n; w++) begin
          if (!done && !win_live[w]) begin
            claim_window(w, req);
            r.idx = IDX_OUT_W'(w);
            done = 1'b1;
          end
        end
        if (done) begin
          r.status = ST_OK;
        end
      end
    end else begin
      r.status = ST_NOT_FOUND;
      for (int unsigned w = 0; w < n; w++) begin
        if (!done && win_live[w] && req.base == {win_base_hi[w], 16'h0000} &&
            req.size == window_span(w)) begin
          release_window(w);
          r.idx = IDX_OUT_W'(w);
          r.status = ST_OK;
          done = 1'b1;
        end
      end
    end
    if (r.status != ST_OK) begin
      r.idx = '0;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    item_t req;
    res_t  want;
    res_t  got;
    if (!rst_ni) begin
      for (int unsigned w = 0; w < MAX_WINDOWS; w++) begin
        win_base_hi[w] = '0;
        win_size_f[w] = '0;
        win_target[w] = '0;
        win_attr[w] = '0;
        win_remap_seg[w] = '0;
      end
      win_live = '0;
      win_in_use = WIN_IN_USE_RST;
      remap_win = REMAP_WIN_RST;
      answer_q.delete();
      fail_count_o = 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_WIN_IN_USE: win_in_use = cfg_wdata_i;
          CFG_REMAP_WIN:  remap_win = cfg_wdata_i;
          default: ;
        endcase
      end
      if (ans_valid_i && ans_ready_i) begin
        got.status = status_e'(ans_data_i[1:0]);
        got.idx = ans_data_i[6:2];
        if (answer_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected result, expected none, actual status %0d index %0d",
                   $time, got.status, got.idx);
        end else begin
          want = answer_q.pop_front();
          if (got.status !== want.status) begin
            fail_count_o++;
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, got.status);
          end
          if (got.idx !== want.idx) begin
            fail_count_o++;
            $display("%0t: window_index mismatch, expected %0d, actual %0d",
                     $time, want.idx, got.idx);
          end
        end
      end
      if (req_valid_i && req_ready_i) begin
        req.kind = req_kind_i;
        req.target = req_data_i[3:0];
        req.attr = req_data_i[11:4];
        req.base = req_data_i[43:12];
        req.size = req_data_i[75:44];
        req.has_remap = req_data_i[76];
        req.remap = req_data_i[108:77];
        answer_q.push_back(update_window_table(req));
      end
      pending_o <= answer_q.size();
    end
  end

endmodule

// ----- tb/address_window_allocator_tb.sv -----
// Top of the address window allocator testbench: clock, reset, settings writes,
// directed and random add/delete items, random backpressure and the verdict.
// Uses awa_pkg, address_window_allocator and address_window_allocator_checker.
module address_window_allocator_tb;
  import awa_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned PHASE_ITEMS    = 112;
  localparam int unsigned PHASES         = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  // phase 0 in the lowest bits
  localparam logic [PHASES*CFG_W-1:0] PHASE_WIN =
    {6'd5, 6'd32, 6'd0, 6'd12, 6'd63, 6'd1, 6'd32, 6'd20};
  localparam logic [PHASES*CFG_W-1:0] PHASE_REMAP =
    {6'd2, 6'd32, 6'd3, 6'd12, 6'd63, 6'd0, 6'd0, 6'd8};

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_addr = '0;
  logic [CFG_W-1:0]       cfg_wdata = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  int unsigned            pending;
  int unsigned            fail_count;
  int unsigned            tx_idle_pct = 17;
  int unsigned            rx_idle_pct = 76;
  int unsigned            idle_cycles = 0;
  logic                   hold_armed = 1'b0;
  logic [63:0]            sent_ranges [$];

  always #2 clk = ~clk;

  address_window_allocator i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  address_window_allocator_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_addr_i   (cfg_addr),
    .cfg_wdata_i  (cfg_wdata),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_i  (s_axis_tready),
    .req_data_i   (s_axis_tdata),
    .req_kind_i   (s_axis_tuser),
    .ans_valid_i  (m_axis_tvalid),
    .ans_ready_i  (m_axis_tready),
    .ans_data_i   (m_axis_tdata),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  function automatic logic [IN_TDATA_W-1:0] pack_request(
    logic [TGT_W-1:0] tgt, logic [ATTR_W-1:0] at, logic [ADDR_W-1:0] base,
    logic [ADDR_W-1:0] size, logic remap_on, logic [ADDR_W-1:0] remap);
    return {3'b000, remap, remap_on, size, base, at, tgt};
  endfunction

  task automatic offer_request(logic kind, logic [IN_TDATA_W-1:0] data);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= data;
    s_axis_tuser <= kind;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic offer_add(logic [TGT_W-1:0] tgt, logic [ATTR_W-1:0] at,
                           logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] size,
                           logic remap_on, logic [ADDR_W-1:0] remap);
    sent_ranges.push_back({base, size});
    if (sent_ranges.size() > 48) begin
      void'(sent_ranges.pop_front());
    end
    offer_request(KIND_ADD, pack_request(tgt, at, base, size, remap_on, remap));
  endtask

  task automatic offer_delete(logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] size);
    offer_request(KIND_DEL, pack_request(4'($urandom), 8'($urandom), base, size,
                                         1'($urandom), $urandom));
  endtask

  task automatic offer_random_request();
    int unsigned       roll;
    logic [63:0]       rng;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] size;
    roll = $urandom_range(0, 99);
    if (roll < 45) begin
      base = {16'($urandom_range(0, 95)), 16'h0000};
      if ($urandom_range(0, 4) == 0) base[15:0] = 16'($urandom);
      size = {16'($urandom_range(1, 4)), 16'h0000};
      if ($urandom_range(0, 6) == 0) size = 32'($urandom_range(0, 32'h3ffff));
      offer_add(4'($urandom), 8'($urandom_range(0, 7)), base, size, 1'($urandom), $urandom);
    end else if (roll < 85 && sent_ranges.size() != 0) begin
      rng = sent_ranges[$urandom_range(0, sent_ranges.size() - 1)];
      base = rng[63:32];
      size = rng[31:0];
      if ($urandom_range(0, 7) == 0) size = size ^ 32'h0001_0000;
      offer_delete(base, size);
    end else begin
      offer_request(1'($urandom), pack_request(4'($urandom), 8'($urandom), $urandom,
                                              $urandom, 1'($urandom), $urandom));
    end
  endtask

  // hold off input until every result is out, then let the block settle
  task automatic drain(int unsigned settle);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_settings(logic [CFG_W-1:0] win, logic [CFG_W-1:0] remap,
                                logic poke_unused);
    drain(8);
    cfg_we <= 1'b1;
    cfg_addr <= CFG_WIN_IN_USE;
    cfg_wdata <= win;
    @(posedge clk);
    cfg_addr <= CFG_REMAP_WIN;
    cfg_wdata <= remap;
    @(posedge clk);
    if (poke_unused) begin
      cfg_addr <= CFG_UNUSED;
      cfg_wdata <= 6'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin : sink
    int unsigned hold_left;
    hold_left = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_armed) begin
        hold_armed = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** address_window_allocator: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: 20 windows, 8 remappable
    offer_add(4'd0, 8'd0, 32'h0001_0000, 32'h0001_0000, 1'b0, 32'h0);
    offer_add(4'd15, 8'd255, 32'hffff_0000, 32'h0001_0000, 1'b1, 32'hffff_ffff);
    offer_add(4'd0, 8'd0, 32'h0010_0000, 32'h0001_0000, 1'b0, 32'h0);
    offer_add(4'd1, 8'd0, 32'h0001_8000, 32'h0000_0100, 1'b0, 32'h0);
    offer_add(4'd2, 8'd0, 32'h0000_0000, 32'h0001_0001, 1'b0, 32'h0);
    offer_add(4'd3, 8'd1, 32'h0003_0000, 32'h0000_0000, 1'b0, 32'h0);
    offer_delete(32'h0003_0000, 32'h0000_0000);
    offer_add(4'd4, 8'd2, 32'h8000_0000, 32'hffff_ffff, 1'b0, 32'h0);
    offer_delete(32'hffff_0000, 32'h0001_0000);
    offer_add(4'd4, 8'd2, 32'h8000_0000, 32'hffff_ffff, 1'b0, 32'h0);
    offer_delete(32'h8000_0000, 32'h0001_0000);
    offer_delete(32'h8000_0000, 32'h0000_0000);
    offer_add(4'd5, 8'd3, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 32'h0);
    offer_delete(32'hffff_0000, 32'hffff_0000);
    offer_delete(32'h0000_0000, 32'h0002_0000);
    offer_delete(32'h0000_0000, 32'h0002_0000);

    write_settings(6'd2, 6'd1, 1'b1);
    offer_add(4'd6, 8'd0, 32'h0040_0000, 32'h0001_0000, 1'b0, 32'h0);
    offer_add(4'd7, 8'd0, 32'h0041_0000, 32'h0001_0000, 1'b0, 32'h0);
    offer_add(4'd8, 8'd0, 32'h0042_0000, 32'h0001_0000, 1'b1, 32'h1234_5678);

    write_settings(6'd0, 6'd0, 1'b0);
    offer_add(4'd9, 8'd9, 32'h0050_0000, 32'h0001_0000, 1'b0, 32'h0);
    offer_delete(32'h0040_0000, 32'h0001_0000);

    for (int unsigned p = 0; p < PHASES; p++) begin
      write_settings(PHASE_WIN[p*CFG_W +: CFG_W], PHASE_REMAP[p*CFG_W +: CFG_W], p == 0);
      if (p < 3) begin
        tx_idle_pct = 17;
        rx_idle_pct = 76;
      end else if (p < 6) begin
        tx_idle_pct = 76;
        rx_idle_pct = 17;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (p == 1) hold_armed = 1'b1;
      repeat (PHASE_ITEMS) offer_random_request();
    end

    drain(40);
    if (fail_count == 0) begin
      $display("** address_window_allocator: PASSED **");
    end else begin
      $display("** address_window_allocator: FAILED **");
    end
    $finish;
  end

endmodule
